@@ rtl/core/kruskal_edge_selector_defines.svh @@
// Assertion macros shared by the edge selector RTL.
`ifndef KRUSKAL_EDGE_SELECTOR_DEFINES_SVH
`define KRUSKAL_EDGE_SELECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define KES_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define KES_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/kes_pkg.sv @@
// Shared widths, register indexes and control types of the edge selector.
package kes_pkg;

  localparam int NODE_IDX_W = 10;  // node_a / node_b field width
  localparam int WEIGHT_W   = 32;  // weight field width
  localparam int LEN_W      = 48;  // tree_length width
  localparam int CNT_OUT_W  = 10;  // edges_taken / missing_edges width
  localparam int NODE_CNT_W = 11;  // node_count register width
  localparam int RANK_W     = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_PARTIAL = 1'd1;

  // Port strobes from a client of the union-find RAM.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

@@ rtl/core/kes_if.sv @@
// Valid/ready channels for edge requests and selection results.
interface kes_edge_if;
  logic                            valid;
  logic                            ready;
  logic [kes_pkg::NODE_IDX_W-1:0]  node_a;
  logic [kes_pkg::NODE_IDX_W-1:0]  node_b;
  logic [kes_pkg::WEIGHT_W-1:0]    weight;
  logic                            blocked;
  logic                            last_edge;

  modport source (output valid, node_a, node_b, weight, blocked, last_edge, input ready);
  modport sink   (input valid, node_a, node_b, weight, blocked, last_edge, output ready);
endinterface

interface kes_result_if;
  logic                            valid;
  logic                            ready;
  logic                            accepted;
  logic [kes_pkg::CNT_OUT_W-1:0]   edges_taken;
  logic [kes_pkg::LEN_W-1:0]       tree_length;
  logic                            tree_complete;
  logic                            bad_node;
  logic                            disconnected;
  logic [kes_pkg::CNT_OUT_W-1:0]   missing_edges;

  modport source (output valid, accepted, edges_taken, tree_length, tree_complete,
                  bad_node, disconnected, missing_edges, input ready);
  modport sink   (input valid, accepted, edges_taken, tree_length, tree_complete,
                  bad_node, disconnected, missing_edges, output ready);
endinterface

@@ rtl/core/kes_ram.sv @@
// Single-port-write, single-port-read union-find RAM, registered read data.
module kes_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 14
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/kes_find.sv @@
// Root search with path compression over the union-find RAM.
module kes_find #(
  parameter int IDX_W  = 10,
  parameter int DATA_W = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [IDX_W-1:0]             node_i,
  input  logic [DATA_W-1:0]            rdata_i,
  output kes_pkg::mem_ctl_t            ctl_o,
  output logic [IDX_W-1:0]             raddr_o,
  output logic [IDX_W-1:0]             waddr_o,
  output logic [DATA_W-1:0]            wdata_o,
  output logic                         done_o,
  output logic [IDX_W-1:0]             root_o,
  output logic [kes_pkg::RANK_W-1:0]   rank_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_WALK = 3'b010,
    F_COMP = 3'b100
  } fstate_e;

  fstate_e                     state_q, state_d;
  logic [IDX_W-1:0]            cur_q, cur_d;    // address of the read in flight
  logic [IDX_W-1:0]            org_q, org_d;
  logic [IDX_W-1:0]            root_q, root_d;
  logic [kes_pkg::RANK_W-1:0]  rank_q, rank_d;
  logic                        done_q, done_d;

  logic [IDX_W-1:0]            par;
  logic [kes_pkg::RANK_W-1:0]  rd_rank;

  assign par     = rdata_i[IDX_W-1:0];
  assign rd_rank = rdata_i[DATA_W-1:IDX_W];

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    org_d       = org_q;
    root_d      = root_q;
    rank_d      = rank_q;
    done_d      = 1'b0;
    ctl_o       = '0;
    raddr_o     = cur_q;
    waddr_o     = cur_q;
    wdata_o     = {rd_rank, root_q};
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          ctl_o.rd_en = 1'b1;
          raddr_o     = node_i;
          cur_d       = node_i;
          org_d       = node_i;
          state_d     = F_WALK;
        end
      end
      F_WALK: begin
        if (par == cur_q) begin
          root_d = cur_q;
          rank_d = rd_rank;
          if (cur_q == org_q) begin
            done_d  = 1'b1;
            state_d = F_IDLE;
          end else begin
            // second walk from the start node rewrites every link to the root
            ctl_o.rd_en = 1'b1;
            raddr_o     = org_q;
            cur_d       = org_q;
            state_d     = F_COMP;
          end
        end else begin
          ctl_o.rd_en = 1'b1;
          raddr_o     = par;
          cur_d       = par;
        end
      end
      F_COMP: begin
        // write cur, read its old parent: never the same entry
        ctl_o.wr_en = 1'b1;
        if (par == root_q) begin
          done_d  = 1'b1;
          state_d = F_IDLE;
        end else begin
          ctl_o.rd_en = 1'b1;
          raddr_o     = par;
          cur_d       = par;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    org_q  <= org_d;
    root_q <= root_d;
    rank_q <= rank_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
  assign rank_o = rank_q;

endmodule

@@ rtl/core/kruskal_edge_selector.sv @@
// Kruskal edge selector: union-find by rank with path compression in one RAM.
// Edges rejected up front (bad index, blocked, tree done) skip the finds and go straight
//   to the result; other edges take longer the deeper the endpoint trees, and a rank tie
//   adds a second link write. The find unit issues one RAM read per cycle.
// Flow: one edge in flight; the next request is taken once its result is in the result register.
// Reset: node_count=2, allow_partial=0; then a pass writes every RAM entry to
//   parent=self, rank=0. The same pass runs after each last edge; edges wait meanwhile.
`include "kruskal_edge_selector_defines.svh"

module kruskal_edge_selector #(
  parameter int MAX_NODES   = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kes_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kes_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  kes_edge_if.sink                         edge_i,
  kes_result_if.source                     result_o
);

  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int DATA_W  = kes_pkg::RANK_W + IDX_W;
  localparam int WB_USED = (WEIGHT_BITS < kes_pkg::WEIGHT_W) ? WEIGHT_BITS : kes_pkg::WEIGHT_W;
  localparam logic [kes_pkg::LEN_W-1:0] W_MASK =
    (kes_pkg::LEN_W'(1) << WB_USED) - kes_pkg::LEN_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_FIND_A = 6'b000100,
    S_FIND_B = 6'b001000,
    S_LINK2  = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [kes_pkg::NODE_CNT_W-1:0] ncnt_q;
  logic                           part_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncnt_q <= kes_pkg::NODE_CNT_W'(2);
      part_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kes_pkg::CFG_NODE_COUNT:    ncnt_q <= cfg_data_i[kes_pkg::NODE_CNT_W-1:0];
        kes_pkg::CFG_ALLOW_PARTIAL: part_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective node count, clamped to [2, MAX_NODES]; need = edges of a full tree.
  logic [31:0]      nc_ext, n_ext;
  logic [IDX_W-1:0] need;

  always_comb begin
    nc_ext = 32'(ncnt_q);
    if (nc_ext < 32'd2) begin
      n_ext = 32'd2;
    end else if (nc_ext > 32'(MAX_NODES)) begin
      n_ext = 32'(MAX_NODES);
    end else begin
      n_ext = nc_ext;
    end
    need = IDX_W'(n_ext - 32'd1);
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e                      state_q, state_d;
  logic [IDX_W-1:0]            clr_q, clr_d;
  logic [IDX_W-1:0]            taken_q, taken_d;
  logic [kes_pkg::LEN_W-1:0]   len_q, len_d;
  logic                        acc_q, acc_d;
  logic [IDX_W-1:0]            ra_q, ra_d;
  logic [kes_pkg::RANK_W-1:0]  rka_q, rka_d;

  // Latched request payload
  logic [IDX_W-1:0]            a_q, b_q;
  logic [kes_pkg::LEN_W-1:0]   w_q;
  logic                        last_q, bad_q;

  logic in_fire, bad_in, elig_in;
  logic [kes_pkg::LEN_W:0] len_sum;

  assign in_fire = edge_i.valid && edge_i.ready;
  assign bad_in  = (32'(edge_i.node_a) >= n_ext) || (32'(edge_i.node_b) >= n_ext);
  assign elig_in = !bad_in && !edge_i.blocked && (taken_q < need);

  // Saturating running length
  assign len_sum = {1'b0, len_q} + {1'b0, w_q};

  // Find unit and RAM ports
  kes_pkg::mem_ctl_t           fnd_ctl;
  logic [IDX_W-1:0]            fnd_raddr, fnd_waddr, fnd_node, fnd_root;
  logic [DATA_W-1:0]           fnd_wdata, mem_rdata;
  logic                        fnd_start, fnd_done;
  logic [kes_pkg::RANK_W-1:0]  fnd_rank;

  logic                        top_we;
  logic [IDX_W-1:0]            top_waddr;
  logic [DATA_W-1:0]           top_wdata;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [DATA_W-1:0]           mem_wdata;

  logic res_load;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    taken_d   = taken_q;
    len_d     = len_q;
    acc_d     = acc_q;
    ra_d      = ra_q;
    rka_d     = rka_q;
    fnd_start = 1'b0;
    fnd_node  = a_q;
    top_we    = 1'b0;
    top_waddr = clr_q;
    top_wdata = {kes_pkg::RANK_W'(0), clr_q};
    res_load  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        // sweep: every node its own root, rank zero
        top_we = 1'b1;
        clr_d  = clr_q + IDX_W'(1);
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          acc_d = 1'b0;
          if (elig_in) begin
            fnd_start = 1'b1;
            fnd_node  = IDX_W'(edge_i.node_a);
            state_d   = S_FIND_A;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_FIND_A: begin
        if (fnd_done) begin
          ra_d      = fnd_root;
          rka_d     = fnd_rank;
          fnd_start = 1'b1;
          fnd_node  = b_q;
          state_d   = S_FIND_B;
        end
      end
      S_FIND_B: begin
        // find unit is idle here, so the link write has the RAM port alone
        if (fnd_done) begin
          if (fnd_root == ra_q) begin
            state_d = S_RESULT;
          end else begin
            acc_d   = 1'b1;
            taken_d = taken_q + IDX_W'(1);
            len_d   = len_sum[kes_pkg::LEN_W] ? '1 : len_sum[kes_pkg::LEN_W-1:0];
            top_we  = 1'b1;
            if (rka_q < fnd_rank) begin
              top_waddr = ra_q;
              top_wdata = {rka_q, fnd_root};
              state_d   = S_RESULT;
            end else begin
              top_waddr = fnd_root;
              top_wdata = {fnd_rank, ra_q};
              // equal ranks: the new root grows one rank in a second write
              state_d   = (rka_q == fnd_rank) ? S_LINK2 : S_RESULT;
            end
          end
        end
      end
      S_LINK2: begin
        top_we    = 1'b1;
        top_waddr = ra_q;
        top_wdata = {(rka_q == kes_pkg::RANK_MAX) ? rka_q
                                                  : rka_q + kes_pkg::RANK_W'(1), ra_q};
        state_d   = S_RESULT;
      end
      S_RESULT: begin
        if (!result_o.valid || result_o.ready) begin
          res_load = 1'b1;
          if (last_q) begin
            // report shows pre-reset totals, then the store starts over
            taken_d = '0;
            len_d   = '0;
            clr_d   = '0;
            state_d = S_CLEAR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      taken_q <= '0;
      len_q   <= '0;
      acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      taken_q <= taken_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q  <= ra_d;
    rka_q <= rka_d;
    if (in_fire) begin
      a_q    <= IDX_W'(edge_i.node_a);
      b_q    <= IDX_W'(edge_i.node_b);
      w_q    <= kes_pkg::LEN_W'(edge_i.weight) & W_MASK;
      last_q <= edge_i.last_edge;
      bad_q  <= bad_in;
    end
  end

  assign edge_i.ready = (state_q == S_IDLE);

  // ---------------------------------------------------------------------------
  // Union-find store: {rank, parent} per node. Sweep and link writes only happen
  // while the find unit is idle, so the two write sources never collide.
  // ---------------------------------------------------------------------------
  assign mem_we    = top_we | fnd_ctl.wr_en;
  assign mem_waddr = top_we ? top_waddr : fnd_waddr;
  assign mem_wdata = top_we ? top_wdata : fnd_wdata;

  kes_ram #(
    .DEPTH  (MAX_NODES),
    .ADDR_W (IDX_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (fnd_ctl.rd_en),
    .raddr_i (fnd_raddr),
    .rdata_o (mem_rdata)
  );

  kes_find #(
    .IDX_W  (IDX_W),
    .DATA_W (DATA_W)
  ) u_find (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fnd_start),
    .node_i  (fnd_node),
    .rdata_i (mem_rdata),
    .ctl_o   (fnd_ctl),
    .raddr_o (fnd_raddr),
    .waddr_o (fnd_waddr),
    .wdata_o (fnd_wdata),
    .done_o  (fnd_done),
    .root_o  (fnd_root),
    .rank_o  (fnd_rank)
  );

  // ---------------------------------------------------------------------------
  // Result register: holds one result so the next request can be taken meanwhile
  // ---------------------------------------------------------------------------
  logic                           out_valid_q;
  logic                           complete;
  logic [IDX_W-1:0]               miss;
  logic                           r_acc_q, r_cmp_q, r_bad_q, r_disc_q;
  logic [kes_pkg::CNT_OUT_W-1:0]  r_taken_q, r_miss_q;
  logic [kes_pkg::LEN_W-1:0]      r_len_q;

  assign complete = (taken_q >= need);
  assign miss     = need - taken_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      r_acc_q   <= acc_q;
      r_taken_q <= kes_pkg::CNT_OUT_W'(taken_q);
      r_len_q   <= len_q;
      r_cmp_q   <= complete;
      r_bad_q   <= bad_q;
      r_disc_q  <= last_q && !complete && !part_q;
      r_miss_q  <= (last_q && !complete) ? kes_pkg::CNT_OUT_W'(miss) : '0;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.accepted      = r_acc_q;
  assign result_o.edges_taken   = r_taken_q;
  assign result_o.tree_length   = r_len_q;
  assign result_o.tree_complete = r_cmp_q;
  assign result_o.bad_node      = r_bad_q;
  assign result_o.disconnected  = r_disc_q;
  assign result_o.missing_edges = r_miss_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `KES_ASSERT_IMP(a_find_done_ctx, clk_i, rst_ni, fnd_done, (state_q == S_FIND_A) || (state_q == S_FIND_B), "find completion outside a find phase")
  `KES_ASSERT_NXT(a_last_restart, clk_i, rst_ni, res_load && last_q, (state_q == S_CLEAR) && (taken_q == '0) && (len_q == '0), "store not restarted after last edge")
  `KES_ASSERT_IMP(a_acc_not_bad, clk_i, rst_ni, result_o.valid && result_o.accepted, !result_o.bad_node, "edge with bad index was accepted")

endmodule
